FILE: sv/mcot_pkg.sv
`default_nettype none

package mcot_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam int unsigned EVENT_W = 4;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  channel;
    logic [31:0] duration;
  } in_t;

  typedef struct packed {
    logic               status;
    logic               expired;
    logic [31:0]        elapsed;
    logic [EVENT_W-1:0] expiry_events;
  } out_t;

  // per-channel strobes from the command decode
  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
  } chan_ctrl_t;

  // per-channel state seen by the result logic
  typedef struct packed {
    logic running;
    logic due;
  } chan_stat_t;

endpackage

`default_nettype wire

FILE: sv/mcot_channel.sv
`default_nettype none

module mcot_channel import mcot_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire chan_ctrl_t            ctrl,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic [TIME_WIDTH-1:0] duration,
  output chan_stat_t                 stat,
  output logic      [TIME_WIDTH-1:0] elapsed
);

  logic                  running;
  logic [TIME_WIDTH-1:0] start_stamp;
  logic [TIME_WIDTH-1:0] run_length;

  // modulo subtraction handles wrap of the shared count
  assign elapsed      = now - start_stamp;
  assign stat.running = running;
  assign stat.due     = elapsed >= run_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (ctrl.start) begin
      running <= 1'b1;
    end else if (ctrl.stop) begin
      running <= 1'b0;
    end else if (ctrl.tick && running && stat.due) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      start_stamp <= now;
      run_length  <= duration;
    end
  end

endmodule

`default_nettype wire

FILE: sv/multi_channel_oneshot_timer.sv
// Bank of NUM_TIMERS one-shot timers on a shared tick count that advances
// on tick commands. A command (tick, start, stop, query) is taken whenever
// start is high and busy is low; busy is only high during reset and the
// cycle after it, so one command per clock is sustained. Each command gives
// one result, shown on rsp for exactly one cycle with done high, via the
// input register and the channel compare logic into the result register.
// The receiver cannot stall, so rsp must be captured in the done cycle. The
// user must write notify_enable through cfg_valid / cfg_ready only while no
// command is in flight; the block itself does not enforce this.
`default_nettype none

module multi_channel_oneshot_timer import mcot_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 4,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_t                req,
  output logic                    done,
  output out_t                    rsp,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [EVENT_W-1:0] cfg_data
);

  logic               in_vld;
  in_t                in_q;
  logic [EVENT_W-1:0] notify_enable;
  logic [TIME_WIDTH-1:0] tick_count;
  logic [TIME_WIDTH-1:0] tick_count_next;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] dur;
  logic                  is_tick;
  logic                  chan_ok;
  out_t                  rsp_next;

  chan_ctrl_t            ctrl     [NUM_TIMERS];
  chan_stat_t            stat     [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] el       [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] sel;
  logic [NUM_TIMERS-1:0] fired;
  logic [EVENT_W-1:0]    events;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      notify_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      notify_enable <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    in_q <= req;
  end

  assign is_tick         = in_vld && (in_q.cmd == CMD_TICK);
  assign chan_ok         = 32'(in_q.channel) < NUM_TIMERS;
  assign tick_count_next = tick_count + TIME_WIDTH'(1);
  // a tick checks expiry against the advanced count
  assign now             = is_tick ? tick_count_next : tick_count;
  assign dur             = TIME_WIDTH'(in_q.duration);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (is_tick) begin
      tick_count <= tick_count_next;
    end
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_chan
    assign sel[i]        = in_vld && (32'(in_q.channel) == i);
    assign ctrl[i].tick  = is_tick;
    assign ctrl[i].start = sel[i] && (in_q.cmd == CMD_START);
    assign ctrl[i].stop  = sel[i] && (in_q.cmd == CMD_STOP);
    assign fired[i]      = stat[i].running && stat[i].due;

    mcot_channel #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_chan (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[i]),
      .now      (now),
      .duration (dur),
      .stat     (stat[i]),
      .elapsed  (el[i])
    );
  end

  for (genvar k = 0; k < EVENT_W; k++) begin : g_evt
    if (k < NUM_TIMERS) begin : g_on
      assign events[k] = fired[k] && notify_enable[k];
    end else begin : g_off
      assign events[k] = 1'b0;
    end
  end

  always_comb begin
    logic [TIME_WIDTH-1:0] el_sel;
    logic                  exp_sel;
    el_sel  = '0;
    exp_sel = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (sel[i] && stat[i].running) begin
        el_sel  = el_sel | el[i];
        exp_sel = exp_sel | stat[i].due;
      end
    end

    rsp_next = '0;
    if (in_q.cmd == CMD_TICK) begin
      rsp_next.expiry_events = events;
    end else if (!chan_ok) begin
      rsp_next.status  = STATUS_INVALID;
      rsp_next.expired = (in_q.cmd == CMD_QUERY);
    end else if (in_q.cmd == CMD_QUERY) begin
      rsp_next.status  = STATUS_OK;
      rsp_next.expired = exp_sel;
      rsp_next.elapsed = 32'(el_sel);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

FILE: sv/mcot_checker.sv
`default_nettype none

module mcot_checker import mcot_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 4
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire in_t  req,
  input wire logic done,
  input wire out_t rsp
);

  // every transfer in gives a done strobe via the input and result registers
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("command accepted without result");

  a_done_caused: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, 2))
    else $error("result without command");

  a_invalid_chan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.cmd != CMD_TICK && 32'(req.channel) >= NUM_TIMERS)
      |-> ##2 (rsp.status == STATUS_INVALID && rsp.elapsed == '0))
    else $error("invalid channel not flagged");

  a_event_clean: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.expiry_events != '0)
      |-> (rsp.status == STATUS_OK && !rsp.expired && rsp.elapsed == '0))
    else $error("tick result carries query fields");

endmodule

bind multi_channel_oneshot_timer mcot_checker #(
  .NUM_TIMERS(NUM_TIMERS)
) u_mcot_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

FILE: tb/timer_bank_monitor.sv
`timescale 1ns / 100ps

module timer_bank_monitor import mcot_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire in_t                req,
  input  wire logic               done,
  input  wire out_t               rsp,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [EVENT_W-1:0] cfg_data,
  output int                      pending,
  output int                      fail_count
);

  localparam int NUM_CH = 4;

  // shadow of the timer bank
  logic [31:0]        tick_now;
  logic [31:0]        stamp [NUM_CH];
  logic [31:0]        length [NUM_CH];
  logic [NUM_CH-1:0]  active;
  logic [EVENT_W-1:0] notify_mask;

  out_t expected_rsp_q[$];

  initial fail_count = 0;

  function automatic out_t predict_timer(in_t item);
    out_t       res;
    logic [1:0] ch;
    logic [31:0] age;
    res = '0;
    ch  = item.channel[1:0];
    if (item.cmd == CMD_TICK) begin
      tick_now = tick_now + 32'd1;
      for (int i = 0; i < NUM_CH; i++) begin
        if (active[i] && (tick_now - stamp[i]) >= length[i]) begin
          active[i] = 1'b0;
          if (notify_mask[i]) res.expiry_events[i] = 1'b1;
        end
      end
    end else if (item.channel >= NUM_CH) begin
      // bad channel: state untouched
      res.status  = STATUS_INVALID;
      res.expired = (item.cmd == CMD_QUERY);
    end else begin
      case (item.cmd)
        CMD_START: begin
          stamp[ch]  = tick_now;
          length[ch] = item.duration;
          active[ch] = 1'b1;
        end
        CMD_STOP: begin
          active[ch] = 1'b0;
        end
        default: begin
          if (active[ch]) begin
            age         = tick_now - stamp[ch];
            res.elapsed = age;
            res.expired = (age >= length[ch]);
          end
        end
      endcase
    end
    return res;
  endfunction

  task automatic note_failure(string what, out_t exp_rsp, out_t got);
    if (fail_count < 10) begin
      $display("%0t: %s: exp status=%0b expired=%0b elapsed=%0h events=%0h",
               $realtime, what, exp_rsp.status, exp_rsp.expired, exp_rsp.elapsed,
               exp_rsp.expiry_events);
      $display("%0t: %s: got status=%0b expired=%0b elapsed=%0h events=%0h",
               $realtime, what, got.status, got.expired, got.elapsed,
               got.expiry_events);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_t exp_rsp;
    if (rst) begin
      tick_now    = '0;
      active      = '0;
      notify_mask = '0;
      for (int i = 0; i < NUM_CH; i++) begin
        stamp[i]  = '0;
        length[i] = '0;
      end
      expected_rsp_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) notify_mask = cfg_data;
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          note_failure("unexpected result", '0, rsp);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp.status !== exp_rsp.status || rsp.expired !== exp_rsp.expired ||
              rsp.elapsed !== exp_rsp.elapsed ||
              rsp.expiry_events !== exp_rsp.expiry_events)
            note_failure("result mismatch", exp_rsp, rsp);
        end
      end
      // command transfer
      if (start && !busy) expected_rsp_q.push_back(predict_timer(req));
      pending <= expected_rsp_q.size();
    end
  end

endmodule

FILE: tb/multi_channel_oneshot_timer_test.sv
`timescale 1ns / 100ps

module multi_channel_oneshot_timer_test;
  import mcot_pkg::*;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  in_t                req = '0;
  logic               cfg_valid = 1'b0;
  logic [EVENT_W-1:0] cfg_data = '0;
  logic               busy;
  logic               done;
  out_t               rsp;
  logic               cfg_ready;
  int                 pending;
  int                 fail_count;

  multi_channel_oneshot_timer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  timer_bank_monitor mon (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** multi_channel_oneshot_timer: FAILED **");
    $finish;
  end

  // leaves start high; caller lowers it for a gap
  task automatic send_cmd(cmd_t op, logic [2:0] ch, logic [31:0] dur);
    in_t item;
    item.cmd      = op;
    item.channel  = ch;
    item.duration = dur;
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_notify(logic [EVENT_W-1:0] mask);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int count);
    int          sent;
    int          burst;
    int          pick;
    bit          drained;
    cmd_t        op;
    logic [2:0]  ch;
    logic [31:0] dur;
    sent    = 0;
    drained = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = CMD_TICK;
        else if (pick < 65) op = CMD_START;
        else if (pick < 75) op = CMD_STOP;
        else                op = CMD_QUERY;
        // mostly live channels, some out of range
        if ($urandom_range(0, 9) == 0) ch = 3'($urandom_range(4, 7));
        else                           ch = 3'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick < 6)       dur = $urandom_range(0, 12);
        else if (pick == 6) dur = '0;
        else if (pick == 7) dur = '1;
        else                dur = $urandom;
        send_cmd(op, ch, dur);
        sent++;
      end
      if (!drained && sent >= count / 2) begin
        drain();
        drained = 1;
      end else if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_notify(4'hF);
    send_cmd(CMD_QUERY, 3'd0, 32'd0);
    send_cmd(CMD_START, 3'd0, 32'd0);
    send_cmd(CMD_QUERY, 3'd0, 32'd0);
    send_cmd(CMD_TICK,  3'd0, 32'd0);          // zero duration expires here
    send_cmd(CMD_QUERY, 3'd0, 32'd0);
    send_cmd(CMD_START, 3'd1, 32'hFFFF_FFFF);
    send_cmd(CMD_START, 3'd2, 32'd2);
    send_cmd(CMD_START, 3'd3, 32'd1);
    send_cmd(CMD_TICK,  3'd7, 32'hFFFF_FFFF);  // tick ignores channel and duration
    send_cmd(CMD_QUERY, 3'd3, 32'd0);
    send_cmd(CMD_TICK,  3'd0, 32'd0);
    send_cmd(CMD_QUERY, 3'd1, 32'd0);
    send_cmd(CMD_START, 3'd1, 32'd5);          // restart while running
    send_cmd(CMD_QUERY, 3'd1, 32'd0);
    send_cmd(CMD_STOP,  3'd1, 32'd0);
    send_cmd(CMD_QUERY, 3'd1, 32'd0);
    send_cmd(CMD_START, 3'd4, 32'd3);
    send_cmd(CMD_STOP,  3'd5, 32'd0);
    send_cmd(CMD_QUERY, 3'd6, 32'd0);
    send_cmd(CMD_QUERY, 3'd7, 32'hFFFF_FFFF);
    send_cmd(CMD_START, 3'd7, 32'hFFFF_FFFF);
    send_cmd(CMD_TICK,  3'd0, 32'd0);

    write_notify(4'h0);
    run_phase(200);
    write_notify(4'hF);
    run_phase(200);
    write_notify(4'h5);
    run_phase(180);
    write_notify(EVENT_W'($urandom_range(0, 15)));
    run_phase(180);
    write_notify(4'hA);
    run_phase(180);
    write_notify(EVENT_W'($urandom_range(0, 15)));
    run_phase(160);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** multi_channel_oneshot_timer: PASSED **");
    else
      $display("** multi_channel_oneshot_timer: FAILED **");
    $finish;
  end

endmodule
